/* sv/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, constants and types of the perspective point projection.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int COEFF_W = 32;
  localparam int COORD_W = 32;
  localparam int COEFF_N = 12;
  localparam int ACC_W   = 58;
  localparam int NUM_W   = ACC_W + 1;
  localparam int SIZE_W  = 14;
  localparam int PROD_W  = NUM_W + SIZE_W;
  localparam int OUT_W   = 21;
  localparam int QSTEPS  = OUT_W + 1;
  localparam int DIV_W   = ACC_W + 1 + OUT_W + 1;

  localparam logic signed [ACC_W-1:0] W_MIN   = 58'sd429496730;
  localparam logic signed [OUT_W-1:0] SCR_MAX = 21'h0FFFFF;
  localparam logic signed [OUT_W-1:0] SCR_MIN = 21'h100000;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PROJECT = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                    start;
    logic [SIZE_W-1:0]       size;
    logic signed [NUM_W-1:0] num;
    logic [ACC_W-1:0]        wval;
  } scale_req_t;

  typedef struct packed {
    logic             load;
    logic [3:0]       idx;
    logic [COEFF_W-1:0] value;
    logic             start;
  } dot_ctl_t;

endpackage

/* sv/ppp_dot.sv */
// ----------------------------------------------------------------------------
// ppp_dot
// Coefficient store and digit-serial multiply-accumulate for the x, y, w rows.
// ----------------------------------------------------------------------------
module ppp_dot import ppp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dot_ctl_t                  ctl_i,
  input  logic signed [COORD_W-1:0] px_i,
  input  logic signed [COORD_W-1:0] py_i,
  input  logic signed [COORD_W-1:0] pz_i,
  output logic                      done_o,
  output logic signed [ACC_W-1:0]   x_o,
  output logic signed [ACC_W-1:0]   y_o,
  output logic signed [ACC_W-1:0]   w_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ACC  = 4'b0100,
    S_OFS  = 4'b1000
  } dot_state_e;

  dot_state_e state_q, state_d;
  logic [COEFF_W-1:0]        coeff_q [COEFF_N];
  logic signed [COORD_W-1:0] pt_q [3];
  logic signed [ACC_W-1:0]   acc_q [3];
  logic signed [63:0]        prod_q, prod_d;
  logic [1:0] row_q, row_d, col_q, col_d;
  logic [2:0] dig_q, dig_d;
  logic       done_q, done_d;

  logic signed [COEFF_W-1:0] c;
  logic signed [COORD_W-1:0] p;
  logic signed [4:0]         d5;
  logic signed [36:0]        pp;
  logic signed [63:0]        term;

  assign c  = coeff_q[{row_q, col_q}];
  assign p  = (col_q == 2'd1) ? pt_q[1] : (col_q == 2'd2) ? pt_q[2] : pt_q[0];
  assign d5 = (dig_q == 3'd7) ? $signed({p[31], p[31:28]})
                              : $signed({1'b0, p[{dig_q, 2'b00} +: 4]});
  assign pp   = c * d5;
  assign term = 64'(pp) <<< {dig_q, 2'b00};

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    dig_d   = dig_q;
    prod_d  = prod_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          state_d = S_MUL;
          row_d   = 2'd0;
          col_d   = 2'd0;
          dig_d   = 3'd0;
        end
      end
      S_MUL: begin
        prod_d = ((dig_q == 3'd0) ? 64'sd0 : prod_q) + term;
        dig_d  = dig_q + 3'd1;
        if (dig_q == 3'd7) state_d = S_ACC;
      end
      S_ACC: begin
        col_d = col_q + 2'd1;
        state_d = (col_q == 2'd2) ? S_OFS : S_MUL;
      end
      S_OFS: begin
        col_d = 2'd0;
        if (row_q == 2'd2) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          row_d   = row_q + 2'd1;
          state_d = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= 2'd0;
      col_q   <= 2'd0;
      dig_q   <= 3'd0;
      done_q  <= 1'b0;
      for (int i = 0; i < COEFF_N; i++) coeff_q[i] <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      dig_q   <= dig_d;
      done_q  <= done_d;
      if (ctl_i.load && (ctl_i.idx < 4'(COEFF_N))) coeff_q[ctl_i.idx] <= ctl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == S_IDLE && ctl_i.start) begin
      pt_q[0] <= px_i;
      pt_q[1] <= py_i;
      pt_q[2] <= pz_i;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end else if (state_q == S_ACC) begin
      acc_q[row_q] <= acc_q[row_q] + ACC_W'(prod_q >>> 8);
    end else if (state_q == S_OFS) begin
      acc_q[row_q] <= acc_q[row_q] + ACC_W'($signed({c, 8'b0}));
    end
  end

  assign done_o = done_q;
  assign x_o    = acc_q[0];
  assign y_o    = acc_q[1];
  assign w_o    = acc_q[2];

endmodule

/* sv/ppp_scale.sv */
// ----------------------------------------------------------------------------
// ppp_scale
// Bit-serial size*|n| product, then restoring division by 2w, saturated.
// ----------------------------------------------------------------------------
module ppp_scale import ppp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scale_req_t              req_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] value_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MULT = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } scl_state_e;

  scl_state_e state_q;
  logic [SIZE_W-1:0] size_q;
  logic [NUM_W-1:0]  mag_q;
  logic              neg_q;
  logic [DIV_W-1:0]  rem_q, dsh_q;
  logic [3:0]        bit_q;
  logic [4:0]        step_q;
  logic              sat_q;
  logic [OUT_W-1:0]  quo_q;
  logic              done_q;
  logic signed [OUT_W-1:0] value_q;

  logic [NUM_W-1:0] mag;
  logic             ge;
  logic [OUT_W:0]   quo_x;

  assign mag   = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
  assign ge    = rem_q >= dsh_q;
  assign quo_x = {1'b0, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      bit_q   <= '0;
      step_q  <= '0;
    end else begin
      done_q <= (state_q == S_FIN);
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            state_q <= S_MULT;
            bit_q   <= 4'(SIZE_W - 1);
          end
        end
        S_MULT: begin
          bit_q <= bit_q - 4'd1;
          if (bit_q == 4'd0) begin
            state_q <= S_DIV;
            step_q  <= '0;
          end
        end
        S_DIV: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(QSTEPS - 1)) state_q <= S_FIN;
        end
        S_FIN: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          size_q <= req_i.size;
          mag_q  <= mag;
          neg_q  <= req_i.num[NUM_W-1];
          rem_q  <= '0;
          dsh_q  <= DIV_W'({req_i.wval, 1'b0}) << OUT_W;
        end
      end
      S_MULT: begin
        rem_q <= {rem_q[DIV_W-2:0], 1'b0} + (size_q[bit_q] ? DIV_W'(mag_q) : '0);
      end
      S_DIV: begin
        if (ge) rem_q <= rem_q - dsh_q;
        if (step_q == 5'd0) sat_q <= ge;
        else quo_q <= {quo_q[OUT_W-2:0], ge};
        dsh_q <= dsh_q >> 1;
      end
      S_FIN: begin
        if (!neg_q) begin
          value_q <= (sat_q || quo_x > 22'd1048575) ? SCR_MAX : $signed(quo_q);
        end else begin
          value_q <= (sat_q || quo_x > 22'd1048576) ? SCR_MIN : OUT_W'(-quo_x);
        end
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

/* sv/perspective_point_projection.sv */
// ----------------------------------------------------------------------------
// perspective_point_projection
// World point to screen pixel through three rows of a view-projection matrix.
//
//   channel | handshake                 | payload
//   in      | in_valid_i / in_ready_o   | action, coeff_index, coeff_value, point
//   out     | out_valid_o / out_ready_i | visible, screen_x, screen_y
//   cfg     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// A load item does not hold the input off. A project item holds the input off
// for the digit-serial dot product (nine 8-digit products, one fold per product,
// one offset per row), then, when visible, each axis in the shared scale unit
// (14 multiply, 22 divide steps), then the move into the output register.
// Reset clears coefficients and sets the screen size to 1920 by 1080.
// A result waits in the output register; a second one stalls the input.
// ----------------------------------------------------------------------------
module perspective_point_projection import ppp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [SIZE_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [3:0]                coeff_index_i,
  input  logic signed [COEFF_W-1:0] coeff_value_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      visible_o,
  output logic signed [OUT_W-1:0]   screen_x_o,
  output logic signed [OUT_W-1:0]   screen_y_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DOT  = 5'b00010,
    S_SX   = 5'b00100,
    S_SY   = 5'b01000,
    S_HOLD = 5'b10000
  } top_state_e;

  top_state_e state_q;
  logic [SIZE_W-1:0] width_q, height_q;
  logic res_vis_q;
  logic signed [OUT_W-1:0] res_sx_q, res_sy_q;
  logic out_valid_q, out_vis_q;
  logic signed [OUT_W-1:0] out_sx_q, out_sy_q;
  logic                    scl_start_q;
  logic [SIZE_W-1:0]       scl_size_q;
  logic signed [NUM_W-1:0] scl_num_q;
  logic [ACC_W-1:0]        scl_wval_q;
  scale_req_t scl_req;
  dot_ctl_t   dctl;

  logic dot_done, scl_done, acc, dot_vis;
  logic signed [ACC_W-1:0] xv, yv, wv;
  logic signed [OUT_W-1:0] scl_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign dot_vis    = !(wv < W_MIN);

  assign dctl.load  = acc && (action_i == ACT_LOAD);
  assign dctl.start = acc && (action_i == ACT_PROJECT);
  assign dctl.idx   = coeff_index_i;
  assign dctl.value = coeff_value_i;

  assign scl_req = '{start: scl_start_q, size: scl_size_q, num: scl_num_q,
                     wval: scl_wval_q};

  ppp_dot u_dot (
    .clk_i, .rst_ni, .ctl_i(dctl),
    .px_i(point_x_i), .py_i(point_y_i), .pz_i(point_z_i),
    .done_o(dot_done), .x_o(xv), .y_o(yv), .w_o(wv)
  );

  ppp_scale u_scale (
    .clk_i, .rst_ni, .req_i(scl_req), .done_o(scl_done), .value_o(scl_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      out_valid_q <= 1'b0;
      scl_start_q <= 1'b0;
    end else begin
      scl_start_q <= (state_q == S_DOT && dot_done && dot_vis) ||
                     (state_q == S_SX && scl_done);
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
      if (state_q == S_HOLD && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (dctl.start) state_q <= S_DOT;
        S_DOT: begin
          if (dot_done) state_q <= dot_vis ? S_SX : S_HOLD;
        end
        S_SX: if (scl_done) state_q <= S_SY;
        S_SY: if (scl_done) state_q <= S_HOLD;
        S_HOLD: if (!out_valid_q || out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_DOT: begin
        res_vis_q  <= dot_vis;
        res_sx_q   <= '0;
        res_sy_q   <= '0;
        scl_size_q <= width_q;
        scl_num_q  <= NUM_W'(wv) + NUM_W'(xv);
        scl_wval_q <= wv;
      end
      S_SX: begin
        if (scl_done) res_sx_q <= scl_val;
        scl_size_q <= height_q;
        scl_num_q  <= NUM_W'(wv) - NUM_W'(yv);
      end
      S_SY: if (scl_done) res_sy_q <= scl_val;
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_vis_q <= res_vis_q;
          out_sx_q  <= res_sx_q;
          out_sy_q  <= res_sy_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;
  assign screen_x_o  = out_sx_q;
  assign screen_y_o  = out_sy_q;

endmodule

/* sv/ppp_checker.sv */
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
module ppp_checker import ppp_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    action_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    visible_o,
  input logic signed [OUT_W-1:0] screen_x_o,
  input logic signed [OUT_W-1:0] screen_y_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_x_o)
      && $stable(screen_y_o) && $stable(visible_o))
    else $error("stalled result changed");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("hidden point with nonzero pixel");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_PROJECT |=> !in_ready_o)
    else $error("ready right after project item");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_LOAD |=> !$rose(out_valid_o))
    else $error("result after load item");

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i,
  .out_valid_o, .out_ready_i, .visible_o, .screen_x_o, .screen_y_o
);
